// ===== sv/bilinear_upscale_2x_assert.svh =====
// Assertion macros for the bilinear 2x upscaler; used by the result sequencer.
// Depends on nothing; the macros expect signals named clk and rst_n in scope.
`ifndef BILINEAR_UPSCALE_2X_ASSERT_SVH
`define BILINEAR_UPSCALE_2X_ASSERT_SVH
`ifndef SYNTHESIS
`define BU2X_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear_upscale_2x assertion failed");
`define BU2X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear_upscale_2x assertion failed");
`else
`define BU2X_ASSERT_SAME(label, ante, cons)
`define BU2X_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/bu2x_pkg.sv =====
// Package for the bilinear 2x upscaler: sizes, register indexes and the job record.
// Depends on nothing.
package bu2x_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int DIM_W = 11;
    localparam int PIX_W = 16;
    localparam int VAL_W = 18;
    localparam int COORD_W = 11;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_BLOCKS = 4;
    localparam int OUT_DATA_W = 40;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0]      pix;
        logic [PIX_W-1:0]      left;
        logic [PIX_W-1:0]      cur;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [NUM_BLOCKS-1:0] blocks;
    } bu2x_job_t;

endpackage

// ===== sv/bu2x_line_buf.sv =====
// Column line buffer: one synchronous RAM with a registered read port.
// Depends on bu2x_pkg.
module bu2x_line_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [bu2x_pkg::ROW_W-1:0]  addr,
    input  logic [bu2x_pkg::PIX_W-1:0]  wdata,
    output logic [bu2x_pkg::PIX_W-1:0]  rdata
);
    import bu2x_pkg::*;

    logic [PIX_W-1:0] mem [MAX_ROWS];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdata_reg <= '0;
        end
        else if (en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bu2x_ctrl.sv =====
// Configuration registers, frame position counters and the input capture stage.
// Depends on bu2x_pkg; drives the line buffer and hands jobs to the emitter.
module bu2x_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bu2x_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bu2x_pkg::PIX_W-1:0]      pixel,
    output logic                            mem_en,
    output logic [bu2x_pkg::ROW_W-1:0]      mem_addr,
    input  logic [bu2x_pkg::PIX_W-1:0]      mem_rdata,
    output logic                            job_valid,
    output bu2x_pkg::bu2x_job_t             job,
    input  logic                            job_take
);
    import bu2x_pkg::*;

    logic [DIM_W-1:0] cols_reg, rows_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] cur_reg;
    logic             s1_valid_reg;
    bu2x_job_t        s1_reg;

    logic [COL_W:0]   cols_eff;
    logic [ROW_W:0]   rows_eff;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [COL_W:0]   c_inc;
    logic [ROW_W:0]   r_inc;
    logic             last_row, last_col, in_acc, cfg_acc, cfg_hit;
    logic [NUM_BLOCKS-1:0] blocks;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_acc && (cfg_index == REG_SOURCE_COLS || cfg_index == REG_SOURCE_ROWS);
    assign s_tready  = !s1_valid_reg || job_take;
    assign in_acc    = s_tvalid && s_tready;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = (COL_W+1)'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            cols_eff = (COL_W+1)'(MAX_COLS);
        end
        else
        begin
            cols_eff = (COL_W+1)'(cols_reg);
        end
        if (rows_reg == '0)
        begin
            rows_eff = (ROW_W+1)'(1);
        end
        else if (32'(rows_reg) > MAX_ROWS)
        begin
            rows_eff = (ROW_W+1)'(MAX_ROWS);
        end
        else
        begin
            rows_eff = (ROW_W+1)'(rows_reg);
        end
    end

    always_comb
    begin
        c = ({1'b0, col_reg} >= cols_eff) ? '0 : col_reg;
        r = ({1'b0, row_reg} >= rows_eff) ? '0 : row_reg;
        last_row = ({1'b0, r} == rows_eff - (ROW_W+1)'(1));
        last_col = ({1'b0, c} == cols_eff - (COL_W+1)'(1));
        blocks[0] = (c != '0) && (r != '0);
        blocks[1] = (c != '0) && last_row;
        blocks[2] = last_col && (r != '0);
        blocks[3] = last_col && last_row;
        r_inc = {1'b0, r} + (ROW_W+1)'(1);
        c_inc = {1'b0, c} + (COL_W+1)'(1);
        row_next = r_inc[ROW_W-1:0];
        col_next = c;
        if (r_inc >= rows_eff)
        begin
            row_next = '0;
            col_next = (c_inc >= cols_eff) ? '0 : c_inc[COL_W-1:0];
        end
    end

    assign mem_en   = in_acc;
    assign mem_addr = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= DIM_RESET;
            rows_reg     <= DIM_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            cur_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc && cfg_index == REG_SOURCE_COLS)
            begin
                cols_reg <= cfg_data;
            end
            if (cfg_acc && cfg_index == REG_SOURCE_ROWS)
            begin
                rows_reg <= cfg_data;
            end
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_acc)
            begin
                cur_reg      <= pixel;
                s1_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg.pix    <= pixel;
            s1_reg.left   <= mem_rdata;
            s1_reg.cur    <= cur_reg;
            s1_reg.col    <= c;
            s1_reg.row    <= r;
            s1_reg.blocks <= blocks;
        end
    end

    assign job_valid = s1_valid_reg;
    assign job       = s1_reg;

endmodule

// ===== sv/bu2x_emit.sv =====
// Result sequencer: walks the 2x2 blocks of one job and feeds the output register.
// Depends on bu2x_pkg and the assertion macro header.
`include "bilinear_upscale_2x_assert.svh"
module bu2x_emit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  bu2x_pkg::bu2x_job_t               job,
    output logic                              job_take,
    input  logic [bu2x_pkg::PIX_W-1:0]        up,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bu2x_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import bu2x_pkg::*;

    bu2x_job_t             cur_reg;
    logic [PIX_W-1:0]      up_reg;
    logic                  busy_reg;
    logic [1:0]            sub_reg;
    logic                  out_valid_reg, out_last_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  out_load, emit, block_end, job_done;
    logic [NUM_BLOCKS-1:0] rest;
    logic [PIX_W-1:0]      a, b, d, e;
    logic [COL_W-1:0]      i;
    logic [ROW_W-1:0]      j;
    logic [VAL_W-1:0]      value;
    logic [COORD_W-1:0]    x, y;

    assign out_load  = !out_valid_reg || m_tready;
    assign emit      = busy_reg && out_load;
    assign block_end = emit && (sub_reg == 2'd3);
    assign rest      = cur_reg.blocks & (cur_reg.blocks - NUM_BLOCKS'(1));
    assign job_done  = block_end && (rest == '0);
    assign job_take  = job_valid && (!busy_reg || job_done);

    always_comb
    begin
        a = cur_reg.pix;
        b = cur_reg.pix;
        d = cur_reg.pix;
        e = cur_reg.pix;
        i = cur_reg.col;
        j = cur_reg.row;
        if (cur_reg.blocks[0])
        begin
            a = cur_reg.left;
            b = cur_reg.cur;
            d = up_reg;
            i = cur_reg.col - COL_W'(1);
            j = cur_reg.row - ROW_W'(1);
        end
        else if (cur_reg.blocks[1])
        begin
            a = up_reg;
            d = up_reg;
            i = cur_reg.col - COL_W'(1);
        end
        else if (cur_reg.blocks[2])
        begin
            a = cur_reg.cur;
            b = cur_reg.cur;
            j = cur_reg.row - ROW_W'(1);
        end
        case (sub_reg)
            2'd0:    value = {a, 2'b00};
            2'd1:    value = {({1'b0, a} + {1'b0, d}), 1'b0};
            2'd2:    value = {({1'b0, a} + {1'b0, b}), 1'b0};
            default: value = VAL_W'(a) + VAL_W'(b) + VAL_W'(d) + VAL_W'(e);
        endcase
        x = COORD_W'({i, sub_reg[1]});
        y = COORD_W'({j, sub_reg[0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg <= (job.blocks != '0);
                sub_reg  <= 2'd0;
            end
            else if (emit)
            begin
                sub_reg <= sub_reg + 2'd1;
                if (job_done)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job;
            up_reg  <= up;
        end
        else if (block_end)
        begin
            cur_reg.blocks <= rest;
        end
        if (emit)
        begin
            out_data_reg <= {value, y, x};
            out_last_reg <= job_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `BU2X_ASSERT_SAME(a_busy_has_blocks, busy_reg, cur_reg.blocks != '0)
    `BU2X_ASSERT_SAME(a_no_overwrite, job_take && busy_reg, job_done)
    `BU2X_ASSERT_NEXT(a_last_ends_job, emit && job_done && !job_take, !busy_reg)
    `BU2X_ASSERT_SAME(a_last_at_block_end, emit && job_done, sub_reg == 2'd3 && $onehot(cur_reg.blocks))

endmodule

// ===== sv/bilinear_upscale_2x.sv =====
// 2x bilinear upscaler for images streamed column by column, rows inner. Each source
// pixel completes the 2x2 output block of its upper-left neighbour, read back from a
// one-column line buffer, and at the last row or column also the clamped edge blocks.
// Results leave one per cycle while m_tready holds; a pixel yields four results in the body
// of the frame and up to sixteen at an edge. A pixel that completes no block yields no
// results. Values are in quarter input LSB. A write to either register restarts the
// frame.
module bilinear_upscale_2x (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bu2x_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: pixel_value[15:0].
    input  logic [bu2x_pkg::PIX_W-1:0]      s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: out_col[10:0], out_row[21:11], out_value[39:22].
    output logic [bu2x_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import bu2x_pkg::*;

    logic             mem_en;
    logic [ROW_W-1:0] mem_addr;
    logic [PIX_W-1:0] mem_rdata;
    logic             job_valid, job_take;
    bu2x_job_t        job;

    bu2x_line_buf u_line_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mem_en),
        .addr  (mem_addr),
        .wdata (s_tdata),
        .rdata (mem_rdata)
    );

    bu2x_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pixel     (s_tdata),
        .mem_en    (mem_en),
        .mem_addr  (mem_addr),
        .mem_rdata (mem_rdata),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    bu2x_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .up        (mem_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
